>>> sv/qvm_pkg.sv
// qvm_pkg: shared widths, fixed-point types and payload structs for the
// quaternion view matrix pipeline. No dependencies.
package qvm_pkg;

  // field widths
  localparam int QW = 16;         // Q1.14 quaternion and axis components
  localparam int PW = 32;         // Q16.16 position and translation

  // rotation and normalization
  localparam int VEC_W = 34;      // Q.28 rotated vector component
  localparam int RED_SHIFT = 4;   // Q.28 to Q.24 reduction
  localparam int R_W = 30;        // reduced component, signed
  localparam int SQ_W = 58;       // square of one reduced component
  localparam int SUM_W = 58;      // sum of three squares
  localparam int ROOT_W = 29;     // integer square root of the sum
  localparam int SQ_STEPS = 29;   // one root bit per stage
  localparam int FRAC = 14;       // fraction bits of Q1.14
  localparam int DIV_W = 44;      // division remainder
  localparam int Q_W = 15;        // quotient magnitude, at most 2^14

  // translation
  localparam int PROD_W = 48;     // axis times position
  localparam int DOT_W = 50;      // sum of three products

  // lanes of the two normalizers
  localparam int AXIS_LANES = 2;
  localparam int SIDE_LANES = 1;

  typedef logic signed [QW-1:0] q14_t;
  typedef logic signed [PW-1:0] fix_t;
  typedef logic signed [VEC_W-1:0] vec_t;

  localparam fix_t FIX_MAX = {1'b0, {(PW-1){1'b1}}};
  localparam fix_t FIX_MIN = {1'b1, {(PW-1){1'b0}}};

  typedef struct packed {
    q14_t quat_w;
    q14_t quat_x;
    q14_t quat_y;
    q14_t quat_z;
    fix_t pos_x;
    fix_t pos_y;
    fix_t pos_z;
  } quat_t;

  typedef struct packed {
    q14_t side_x;
    q14_t side_y;
    q14_t side_z;
    q14_t up_x;
    q14_t up_y;
    q14_t up_z;
    q14_t fwd_x;
    q14_t fwd_y;
    q14_t fwd_z;
    fix_t trans_side;
    fix_t trans_up;
    fix_t trans_fwd;
  } view_t;

  typedef struct packed {
    fix_t x;
    fix_t y;
    fix_t z;
  } pos_t;

  // what travels beside the side axis while it is formed and normalized
  typedef struct packed {
    q14_t [2:0] up;
    q14_t [2:0] fwd;
    pos_t       pos;
  } frame_t;

endpackage

>>> sv/qvm_stream_if.sv
// qvm_stream_if: valid/ready channel with a typed payload.
// Used for the quaternion input and the view matrix output; no dependencies.
interface qvm_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/qvm_rotate.sv
// qvm_rotate: rotates the forward and up unit vectors by a quaternion,
// exact Q.28 result in two stages. Depends on qvm_pkg.
module qvm_rotate (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               vin,
  input  qvm_pkg::quat_t     item,
  output logic               vout,
  output qvm_pkg::vec_t [2:0] fwd_rot,
  output qvm_pkg::vec_t [2:0] up_rot,
  output qvm_pkg::pos_t      pos
);
  import qvm_pkg::*;

  logic v1;
  logic signed [2*QW-1:0] ww, xx, yy, zz, xz, wy, yz, wx, xy, wz;
  pos_t pos1;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      vout <= v1;
    end
  end

  // stage 1: all pairwise products
  always_ff @(posedge clk) begin
    if (en) begin
      ww   <= item.quat_w * item.quat_w;
      xx   <= item.quat_x * item.quat_x;
      yy   <= item.quat_y * item.quat_y;
      zz   <= item.quat_z * item.quat_z;
      xz   <= item.quat_x * item.quat_z;
      wy   <= item.quat_w * item.quat_y;
      yz   <= item.quat_y * item.quat_z;
      wx   <= item.quat_w * item.quat_x;
      xy   <= item.quat_x * item.quat_y;
      wz   <= item.quat_w * item.quat_z;
      pos1 <= '{x: item.pos_x, y: item.pos_y, z: item.pos_z};
    end
  end

  // stage 2: combine into rotated forward and up
  always_ff @(posedge clk) begin
    if (en) begin
      fwd_rot[0] <= (vec_t'(xz) + vec_t'(wy)) <<< 1;
      fwd_rot[1] <= (vec_t'(yz) - vec_t'(wx)) <<< 1;
      fwd_rot[2] <= vec_t'(ww) - vec_t'(xx) - vec_t'(yy) + vec_t'(zz);
      up_rot[0]  <= (vec_t'(xy) - vec_t'(wz)) <<< 1;
      up_rot[1]  <= vec_t'(ww) - vec_t'(xx) + vec_t'(yy) - vec_t'(zz);
      up_rot[2]  <= (vec_t'(yz) + vec_t'(wx)) <<< 1;
      pos        <= pos1;
    end
  end

endmodule

>>> sv/qvm_normalize.sv
// qvm_normalize: pipelined renormalization of Q.28 vectors to Q1.14,
// one square-root bit and one quotient bit per stage. Depends on qvm_pkg.
module qvm_normalize #(
  parameter int LANES = qvm_pkg::AXIS_LANES,
  parameter int SB_W  = qvm_pkg::PW
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              vin,
  input  qvm_pkg::vec_t [LANES-1:0][2:0]    vec_in,
  input  logic [SB_W-1:0]                   sb_in,
  output logic                              vout,
  output qvm_pkg::q14_t [LANES-1:0][2:0]    nrm,
  output logic [SB_W-1:0]                   sb_out
);
  import qvm_pkg::*;

  localparam int DIV_STEPS = Q_W;
  // reduce, square, sum, root steps, divide setup, divide steps, sign
  localparam int DEPTH = 3 + SQ_STEPS + 1 + DIV_STEPS + 1;

  typedef logic signed [R_W-1:0] red_t;

  logic [DEPTH-1:0] v;
  logic [SB_W-1:0]  sb [DEPTH];

  red_t [2:0]        red_a [LANES];
  red_t [2:0]        red_b [LANES];
  logic [SQ_W-1:0]   sq_b  [LANES][3];
  red_t [2:0]        red_s [SQ_STEPS+1][LANES];
  logic [SUM_W-1:0]  n_s   [SQ_STEPS+1][LANES];
  logic [SUM_W:0]    res_s [SQ_STEPS+1][LANES];

  logic [DIV_W-1:0]  rem_q  [DIV_STEPS+1][LANES][3];
  logic [Q_W-1:0]    quo_q  [DIV_STEPS+1][LANES][3];
  logic [ROOT_W-1:0] len_q  [DIV_STEPS+1][LANES];
  logic [2:0]        neg_q  [DIV_STEPS+1][LANES];
  logic              zero_q [DIV_STEPS+1][LANES];

  // Q.28 to Q.24, truncating toward zero
  function automatic red_t reduce(input vec_t val);
    vec_t bias;
    vec_t shifted;
    bias    = val[VEC_W-1] ? vec_t'((1 << RED_SHIFT) - 1) : '0;
    shifted = (val + bias) >>> RED_SHIFT;
    return shifted[R_W-1:0];
  endfunction

  // valid bits and sideband travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[DEPTH-2:0], vin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= sb_in;
      for (int k = 1; k < DEPTH; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  assign vout   = v[DEPTH-1];
  assign sb_out = sb[DEPTH-1];

  // reduce, square, sum, then one root bit per stage
  always_ff @(posedge clk) begin
    red_t                   rv;
    logic signed [2*R_W-1:0] sq_full;
    logic [SUM_W:0]         step;
    logic [SUM_W:0]         trial;
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        for (int c = 0; c < 3; c++) begin
          red_a[l][c] <= reduce(vec_in[l][c]);
          rv          = red_a[l][c];
          sq_full     = rv * rv;
          sq_b[l][c]  <= sq_full[SQ_W-1:0];
        end
        red_b[l]    <= red_a[l];
        n_s[0][l]   <= sq_b[l][0] + sq_b[l][1] + sq_b[l][2];
        res_s[0][l] <= '0;
        red_s[0][l] <= red_b[l];
      end
      for (int k = 0; k < SQ_STEPS; k++) begin
        for (int l = 0; l < LANES; l++) begin
          step  = (SUM_W+1)'(1) << (SUM_W - 2 - 2*k);
          trial = res_s[k][l] + step;
          if ({1'b0, n_s[k][l]} >= trial) begin
            n_s[k+1][l]   <= n_s[k][l] - trial[SUM_W-1:0];
            res_s[k+1][l] <= (res_s[k][l] >> 1) + step;
          end else begin
            n_s[k+1][l]   <= n_s[k][l];
            res_s[k+1][l] <= res_s[k][l] >> 1;
          end
          red_s[k+1][l] <= red_s[k][l];
        end
      end
    end
  end

  // divide setup, one quotient bit per stage, then sign and zero length
  always_ff @(posedge clk) begin
    logic [ROOT_W-1:0] len;
    red_t              rv;
    logic [R_W-1:0]    mag;
    logic [DIV_W-1:0]  dv;
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        len          = res_s[SQ_STEPS][l][ROOT_W-1:0];
        len_q[0][l]  <= len;
        zero_q[0][l] <= (len == '0);
        for (int c = 0; c < 3; c++) begin
          rv  = red_s[SQ_STEPS][l][c];
          mag = rv[R_W-1] ? R_W'(-rv) : R_W'(rv);
          rem_q[0][l][c] <= (DIV_W'(mag) << FRAC) + DIV_W'(len >> 1);
          quo_q[0][l][c] <= '0;
          neg_q[0][l][c] <= rv[R_W-1];
        end
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        for (int l = 0; l < LANES; l++) begin
          len_q[j+1][l]  <= len_q[j][l];
          zero_q[j+1][l] <= zero_q[j][l];
          neg_q[j+1][l]  <= neg_q[j][l];
          for (int c = 0; c < 3; c++) begin
            dv = DIV_W'(len_q[j][l]) << (Q_W - 1 - j);
            if (rem_q[j][l][c] >= dv) begin
              rem_q[j+1][l][c] <= rem_q[j][l][c] - dv;
              quo_q[j+1][l][c] <= quo_q[j][l][c] | (Q_W'(1) << (Q_W - 1 - j));
            end else begin
              rem_q[j+1][l][c] <= rem_q[j][l][c];
              quo_q[j+1][l][c] <= quo_q[j][l][c];
            end
          end
        end
      end
      for (int l = 0; l < LANES; l++) begin
        for (int c = 0; c < 3; c++) begin
          if (zero_q[DIV_STEPS][l]) begin
            nrm[l][c] <= '0;
          end else if (neg_q[DIV_STEPS][l][c]) begin
            nrm[l][c] <= -q14_t'(quo_q[DIV_STEPS][l][c]);
          end else begin
            nrm[l][c] <= q14_t'(quo_q[DIV_STEPS][l][c]);
          end
        end
      end
    end
  end

endmodule

>>> sv/qvm_cross.sv
// qvm_cross: side = up x forward in exact Q.28, two stages, carrying the
// frame alongside. Depends on qvm_pkg.
module qvm_cross (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vin,
  input  qvm_pkg::frame_t     fin,
  output logic                vout,
  output qvm_pkg::vec_t [2:0] side_rot,
  output qvm_pkg::frame_t     fout
);
  import qvm_pkg::*;

  logic v1;
  logic signed [2*QW-1:0] p [6];
  frame_t f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1   <= vin;
      vout <= v1;
    end
  end

  // stage 1: six products
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= fin.up[1] * fin.fwd[2];
      p[1] <= fin.up[2] * fin.fwd[1];
      p[2] <= fin.up[2] * fin.fwd[0];
      p[3] <= fin.up[0] * fin.fwd[2];
      p[4] <= fin.up[0] * fin.fwd[1];
      p[5] <= fin.up[1] * fin.fwd[0];
      f1   <= fin;
    end
  end

  // stage 2: differences
  always_ff @(posedge clk) begin
    if (en) begin
      side_rot[0] <= vec_t'(p[0]) - vec_t'(p[1]);
      side_rot[1] <= vec_t'(p[2]) - vec_t'(p[3]);
      side_rot[2] <= vec_t'(p[4]) - vec_t'(p[5]);
      fout        <= f1;
    end
  end

endmodule

>>> sv/qvm_translate.sv
// qvm_translate: negated, rounded and saturated dot products of the three
// axes with the position, four stages. Depends on qvm_pkg.
module qvm_translate (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 vin,
  input  qvm_pkg::q14_t [2:0]  side,
  input  qvm_pkg::frame_t      fin,
  output logic                 vout,
  output qvm_pkg::view_t       res
);
  import qvm_pkg::*;

  localparam int RND_W = DOT_W - FRAC + 1;

  logic [3:0] v;
  q14_t [2:0] axis_in [3];
  fix_t [2:0] pos_in;
  q14_t [2:0] ax [3][3];
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [DOT_W-1:0]  dot  [3];
  logic signed [RND_W-1:0]  rnd  [3];

  function automatic fix_t sat(input logic signed [RND_W-1:0] val);
    logic [RND_W-PW:0] hi;
    hi = val[RND_W-1:PW-1];
    if ((&hi) || !(|hi)) begin
      return val[PW-1:0];
    end
    return val[RND_W-1] ? FIX_MIN : FIX_MAX;
  endfunction

  assign axis_in[0] = side;
  assign axis_in[1] = fin.up;
  assign axis_in[2] = fin.fwd;
  assign pos_in[0]  = fin.pos.x;
  assign pos_in[1]  = fin.pos.y;
  assign pos_in[2]  = fin.pos.z;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], vin};
    end
  end

  assign vout = v[3];

  always_ff @(posedge clk) begin
    logic [DOT_W-1:0]        mag;
    logic [DOT_W-1:0]        rounded;
    logic signed [RND_W-1:0] qs;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        // stage 1: products
        for (int c = 0; c < 3; c++) begin
          prod[a][c] <= axis_in[a][c] * pos_in[c];
        end
        ax[0][a] <= axis_in[a];
        // stage 2: dot product
        dot[a]   <= DOT_W'(prod[a][0]) + DOT_W'(prod[a][1]) + DOT_W'(prod[a][2]);
        ax[1][a] <= ax[0][a];
        // stage 3: round to nearest, ties away from zero, and negate
        mag     = dot[a][DOT_W-1] ? DOT_W'(-dot[a]) : DOT_W'(dot[a]);
        rounded = (mag + DOT_W'(1 << (FRAC - 1))) >> FRAC;
        qs      = {1'b0, rounded[DOT_W-FRAC-1:0]};
        rnd[a]  <= dot[a][DOT_W-1] ? qs : -qs;
        ax[2][a] <= ax[1][a];
      end
      // stage 4: saturate and assemble
      res.side_x     <= ax[2][0][0];
      res.side_y     <= ax[2][0][1];
      res.side_z     <= ax[2][0][2];
      res.up_x       <= ax[2][1][0];
      res.up_y       <= ax[2][1][1];
      res.up_z       <= ax[2][1][2];
      res.fwd_x      <= ax[2][2][0];
      res.fwd_y      <= ax[2][2][1];
      res.fwd_z      <= ax[2][2][2];
      res.trans_side <= sat(rnd[0]);
      res.trans_up   <= sat(rnd[1]);
      res.trans_fwd  <= sat(rnd[2]);
    end
  end

endmodule

>>> sv/quaternion_view_matrix.sv
// quaternion_view_matrix: quaternion and position in, view basis and
// translations out. Throughput one item per cycle while the pipeline is not held;
// the pipeline (two square-root/divider chains) holds as a whole only when its
// last stage and the output register are full and view.ready is low.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on qvm_pkg, qvm_stream_if and the qvm_* stage modules.
module quaternion_view_matrix (
  input logic          clk,
  input logic          rst,
  qvm_stream_if.sink   quat,
  qvm_stream_if.source view
);
  import qvm_pkg::*;

  logic en;
  logic rot_v, n1_v, cr_v, n2_v, tr_v;
  vec_t [2:0] fwd_rot, up_rot, side_rot;
  pos_t rot_pos;
  vec_t [AXIS_LANES-1:0][2:0] vec1;
  q14_t [AXIS_LANES-1:0][2:0] nrm1;
  logic [$bits(pos_t)-1:0] sb1;
  frame_t fr1, fr2;
  vec_t [SIDE_LANES-1:0][2:0] vec2;
  q14_t [SIDE_LANES-1:0][2:0] nrm2;
  logic [$bits(frame_t)-1:0] sb2;
  view_t tr_res;
  logic  out_valid;
  view_t out_data;

  // whole pipeline moves unless the finished item has nowhere to go
  assign en         = !out_valid || view.ready || !tr_v;
  assign quat.ready = en;

  qvm_rotate u_rotate (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vin     (quat.valid),
    .item    (quat.data),
    .vout    (rot_v),
    .fwd_rot (fwd_rot),
    .up_rot  (up_rot),
    .pos     (rot_pos)
  );

  assign vec1[0] = fwd_rot;
  assign vec1[1] = up_rot;

  qvm_normalize #(
    .LANES (AXIS_LANES),
    .SB_W  ($bits(pos_t))
  ) u_norm_axes (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vin    (rot_v),
    .vec_in (vec1),
    .sb_in  (rot_pos),
    .vout   (n1_v),
    .nrm    (nrm1),
    .sb_out (sb1)
  );

  assign fr1.fwd = nrm1[0];
  assign fr1.up  = nrm1[1];
  assign fr1.pos = pos_t'(sb1);

  qvm_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .vin      (n1_v),
    .fin      (fr1),
    .vout     (cr_v),
    .side_rot (side_rot),
    .fout     (fr2)
  );

  assign vec2[0] = side_rot;

  qvm_normalize #(
    .LANES (SIDE_LANES),
    .SB_W  ($bits(frame_t))
  ) u_norm_side (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .vin    (cr_v),
    .vec_in (vec2),
    .sb_in  (fr2),
    .vout   (n2_v),
    .nrm    (nrm2),
    .sb_out (sb2)
  );

  qvm_translate u_translate (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .vin  (n2_v),
    .side (nrm2[0]),
    .fin  (frame_t'(sb2)),
    .vout (tr_v),
    .res  (tr_res)
  );

  // output register, refilled whenever it is empty or its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || view.ready) begin
      out_valid <= tr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || view.ready) begin
      out_data <= tr_res;
    end
  end

  assign view.valid = out_valid;
  assign view.data  = out_data;

endmodule

>>> dv/quaternion_view_matrix_tb.sv
// quaternion_view_matrix_tb: drives quaternion and position items through the
// view matrix pipeline and checks every basis entry and translation against a
// local fixed-point predictor. Depends on qvm_pkg, qvm_stream_if and the RTL.
module quaternion_view_matrix_tb;
  import qvm_pkg::*;

  // scoreboard: predicts the view matrix of each accepted transfer
  class view_board;
    view_t pending[$];
    int errors;
    int seen;

    function longint unsigned root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint round_div(longint num, longint den);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void unit_axis(input longint v[3], output longint o[3]);
      longint r[3];
      longint unsigned acc, len;
      longint t;
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        r[i] = v[i] / 16;
        acc += r[i] * r[i];
      end
      len = root_floor(acc);
      for (int i = 0; i < 3; i++) begin
        if (len == 0) begin
          o[i] = 0;
        end else begin
          t = round_div(r[i] * 16384, longint'(len));
          if (t > 16384) t = 16384;
          if (t < -16384) t = -16384;
          o[i] = t;
        end
      end
    endfunction

    function fix_t offset(longint a[3], longint p[3]);
      longint t;
      t = -round_div(a[0] * p[0] + a[1] * p[1] + a[2] * p[2], 16384);
      if (t > 64'sd2147483647) return FIX_MAX;
      if (t < -64'sd2147483648) return FIX_MIN;
      return fix_t'(t);
    endfunction

    function void note_input(quat_t q);
      longint w, x, y, z;
      longint p[3], fr[3], ur[3], sr[3], f[3], u[3], s[3];
      view_t e;
      w = q.quat_w; x = q.quat_x; y = q.quat_y; z = q.quat_z;
      p[0] = q.pos_x; p[1] = q.pos_y; p[2] = q.pos_z;
      fr[0] = 2 * (x * z + w * y);
      fr[1] = 2 * (y * z - w * x);
      fr[2] = w * w - x * x - y * y + z * z;
      ur[0] = 2 * (x * y - w * z);
      ur[1] = w * w - x * x + y * y - z * z;
      ur[2] = 2 * (y * z + w * x);
      unit_axis(fr, f);
      unit_axis(ur, u);
      sr[0] = u[1] * f[2] - u[2] * f[1];
      sr[1] = u[2] * f[0] - u[0] * f[2];
      sr[2] = u[0] * f[1] - u[1] * f[0];
      unit_axis(sr, s);
      e.side_x = q14_t'(s[0]); e.side_y = q14_t'(s[1]); e.side_z = q14_t'(s[2]);
      e.up_x = q14_t'(u[0]); e.up_y = q14_t'(u[1]); e.up_z = q14_t'(u[2]);
      e.fwd_x = q14_t'(f[0]); e.fwd_y = q14_t'(f[1]); e.fwd_z = q14_t'(f[2]);
      e.trans_side = offset(s, p);
      e.trans_up = offset(u, p);
      e.trans_fwd = offset(f, p);
      pending.push_back(e);
    endfunction

    function void field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(view_t a);
      view_t e;
      seen++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected view result", $time);
        return;
      end
      e = pending.pop_front();
      field("side_x", e.side_x, a.side_x);
      field("side_y", e.side_y, a.side_y);
      field("side_z", e.side_z, a.side_z);
      field("up_x", e.up_x, a.up_x);
      field("up_y", e.up_y, a.up_y);
      field("up_z", e.up_z, a.up_z);
      field("fwd_x", e.fwd_x, a.fwd_x);
      field("fwd_y", e.fwd_y, a.fwd_y);
      field("fwd_z", e.fwd_z, a.fwd_z);
      field("trans_side", e.trans_side, a.trans_side);
      field("trans_up", e.trans_up, a.trans_up);
      field("trans_fwd", e.trans_fwd, a.trans_fwd);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  qvm_stream_if #(.T(quat_t)) quat ();
  qvm_stream_if #(.T(view_t)) view ();
  view_board board = new();
  bit hold_long = 1'b0;
  int sent = 0;

  quaternion_view_matrix DUT (.clk(clk), .rst(rst), .quat(quat), .view(view));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // monitor both transfers at the sampling edge
  always @(posedge clk) begin
    if (!rst && quat.valid && quat.ready) board.note_input(quat.data);
    if (!rst && view.valid && view.ready) board.check_result(view.data);
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  function automatic q14_t q_comp();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return q14_t'($urandom);
      default: return q14_t'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic fix_t pos_comp();
    case ($urandom_range(0, 4))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return fix_t'($urandom_range(0, 2000000) - 1000000);
      default: return fix_t'($urandom);
    endcase
  endfunction

  // unit quaternion built from four random components scaled to unit length, most stimulus
  function automatic quat_t unit_item();
    quat_t q;
    real a, b, c, d, n;
    a = $urandom_range(0, 2000) - 1000.0;
    b = $urandom_range(0, 2000) - 1000.0;
    c = $urandom_range(0, 2000) - 1000.0;
    d = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(a * a + b * b + c * c + d * d);
    if (n == 0.0) begin
      a = 1.0;
      n = 1.0;
    end
    q.quat_w = q14_t'($rtoi(a / n * 16384.0));
    q.quat_x = q14_t'($rtoi(b / n * 16384.0));
    q.quat_y = q14_t'($rtoi(c / n * 16384.0));
    q.quat_z = q14_t'($rtoi(d / n * 16384.0));
    q.pos_x = pos_comp(); q.pos_y = pos_comp(); q.pos_z = pos_comp();
    return q;
  endfunction

  task automatic send_item(quat_t q);
    int g;
    g = gap_len();
    if (g > 0) begin
      quat.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    quat.valid <= 1'b1;
    quat.data <= q;
    @(posedge clk);
    while (!quat.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_directed(q14_t w, q14_t x, q14_t y, q14_t z,
                               fix_t px, fix_t py, fix_t pz);
    quat_t q;
    q = '{w, x, y, z, px, py, pz};
    send_item(q);
  endtask

  // receiver stalls, including one long hold-off while the input backs up
  initial begin
    int g;
    view.ready = 1'b0;
    @(negedge rst);
    while (1) begin
      @(posedge clk);
      if (hold_long) begin
        view.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      g = gap_len();
      if (g > 0) begin
        view.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      view.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin
    quat_t q;
    quat.valid = 1'b0;
    quat.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: identity, extremes, zero quaternion, parallel axes, saturation
    send_directed(16384, 0, 0, 0, 0, 0, 0);
    send_directed(-16384, 0, 0, 0, FIX_MAX, FIX_MAX, FIX_MAX);
    send_directed(0, 0, 0, 0, FIX_MIN, FIX_MIN, FIX_MIN);
    send_directed(16384, 16384, 16384, 16384, FIX_MAX, FIX_MIN, FIX_MAX);
    send_directed(-16384, -16384, -16384, -16384, FIX_MIN, FIX_MAX, FIX_MIN);
    send_directed(11585, 11585, 0, 0, 65536, -65536, 65536);
    send_directed(0, 16384, 0, 0, 1, -1, 1);
    send_directed(0, 0, 16384, 0, FIX_MAX, 0, FIX_MIN);
    send_directed(0, 0, 0, 16384, 0, FIX_MAX, 0);
    send_directed(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, -1, -1, -1);
    send_directed(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, FIX_MIN, FIX_MIN, FIX_MIN);
    send_directed(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, FIX_MAX, FIX_MAX, FIX_MIN);
    send_directed(1, 0, 0, 0, 100, 200, 300);
    send_directed(0, 1, 1, 0, FIX_MAX, FIX_MAX, FIX_MAX);
    send_directed(8192, 8192, 8192, 8192, 12345678, -87654321, 5555);
    send_directed(16384, 0, 0, 0, FIX_MIN, 0, FIX_MAX);
    // random: mostly unit quaternions, the rest raw noise
    for (int i = 0; i < 540; i++) begin
      if (i == 200) hold_long = 1'b1;
      if ($urandom_range(0, 3) != 0) begin
        q = unit_item();
      end else begin
        q.quat_w = q_comp(); q.quat_x = q_comp();
        q.quat_y = q_comp(); q.quat_z = q_comp();
        q.pos_x = pos_comp(); q.pos_y = pos_comp(); q.pos_z = pos_comp();
      end
      send_item(q);
    end
    quat.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("covered %0d transfers in, %0d view results checked", sent, board.seen);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

>>> quaternion_view_matrix.f
sv/qvm_pkg.sv
sv/qvm_stream_if.sv
sv/qvm_rotate.sv
sv/qvm_normalize.sv
sv/qvm_cross.sv
sv/qvm_translate.sv
sv/quaternion_view_matrix.sv
dv/quaternion_view_matrix_tb.sv
